// ===== src/crrm_pkg.sv =====
// ----------------------------------------------------------------------------
// crrm_pkg: shared types for the coalescing range rights map
// Command and status groups passed between controller and datapath.
// ----------------------------------------------------------------------------
package crrm_pkg;

    // controller -> datapath
    typedef struct packed {
        logic load_item;   // capture input beat, reset coverage walk
        logic clr_count;   // clear item: empty the table
        logic idx_clr;     // reset entry index
        logic idx_inc;     // advance entry index
        logic tbl_rd;      // read table entry at index
        logic cov_eval;    // coverage walk step on read entry
        logic bld_init;    // start of rebuild pass
        logic bld_arrive;  // split read entry into pieces
        logic tail_arm;    // arm trailing gap piece
        logic push;        // push one pending piece into coalescer
        logic flush;       // write held span into scratch
        logic copy_rd;     // read scratch at index
        logic copy_wr;     // write table at index
        logic commit;      // new count takes effect
    } crrm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_mode;  // item is a clear
        logic empty_range; // start >= end
        logic scan_end;    // index reached entry count
        logic cov_true;    // walk found full coverage
        logic push_more;   // pieces still pending
        logic ovf;         // rebuilt list exceeds table
        logic copy_end;    // index reached rebuilt count
    } crrm_sts_t;

endpackage

// ===== src/crrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// crrm_ctrl: sequencer for the range rights map
// Steps an add item through coverage scan and, if not covered, rebuild, coalesce and copy-back.
// ----------------------------------------------------------------------------
module crrm_ctrl
    import crrm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_beat,
    input  logic      out_free,
    input  crrm_sts_t sts,
    output crrm_cmd_t cmd,
    output logic      idle,
    output logic      res_load,
    output logic      res_cov,
    output logic      res_ovf
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_C_RD   = 4'd2;
    localparam logic [3:0] S_C_EV   = 4'd3;
    localparam logic [3:0] S_C_END  = 4'd4;
    localparam logic [3:0] S_B_RD   = 4'd5;
    localparam logic [3:0] S_B_AR   = 4'd6;
    localparam logic [3:0] S_B_PU   = 4'd7;
    localparam logic [3:0] S_B_TAIL = 4'd8;
    localparam logic [3:0] S_B_CHK  = 4'd9;
    localparam logic [3:0] S_K_CHK  = 4'd10;
    localparam logic [3:0] S_K_WR   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       cov_reg, cov_next;
    logic       ovf_reg, ovf_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cov_next   = cov_reg;
        ovf_next   = ovf_reg;
        cmd        = '0;
        res_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cov_next = 1'b0;
                ovf_next = 1'b0;
                if (sts.clear_mode)
                begin
                    cmd.clr_count = 1'b1;
                    state_next    = S_DONE;
                end
                else if (sts.empty_range)
                begin
                    cov_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_C_RD;
                end
            end
            S_C_RD:
            begin
                if (sts.scan_end)
                begin
                    state_next = S_C_END;
                end
                else
                begin
                    cmd.tbl_rd = 1'b1;
                    state_next = S_C_EV;
                end
            end
            S_C_EV:
            begin
                cmd.cov_eval = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_C_RD;
            end
            S_C_END:
            begin
                if (sts.cov_true)
                begin
                    cov_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.bld_init = 1'b1;
                    state_next   = S_B_RD;
                end
            end
            S_B_RD:
            begin
                if (sts.scan_end)
                begin
                    cmd.tail_arm = 1'b1;
                    state_next   = S_B_TAIL;
                end
                else
                begin
                    cmd.tbl_rd = 1'b1;
                    state_next = S_B_AR;
                end
            end
            S_B_AR:
            begin
                cmd.bld_arrive = 1'b1;
                cmd.idx_inc    = 1'b1;
                state_next     = S_B_PU;
            end
            S_B_PU:
            begin
                if (sts.push_more)
                begin
                    cmd.push = 1'b1;
                end
                else
                begin
                    state_next = S_B_RD;
                end
            end
            S_B_TAIL:
            begin
                if (sts.push_more)
                begin
                    cmd.push = 1'b1;
                end
                else
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_B_CHK;
                end
            end
            S_B_CHK:
            begin
                if (sts.ovf)
                begin
                    ovf_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_K_CHK;
                end
            end
            S_K_CHK:
            begin
                if (sts.copy_end)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.copy_rd = 1'b1;
                    state_next  = S_K_WR;
                end
            end
            S_K_WR:
            begin
                cmd.copy_wr = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = S_K_CHK;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cov_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cov_reg   <= cov_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign idle    = (state_reg == S_IDLE);
    assign res_cov = cov_reg;
    assign res_ovf = ovf_reg;

endmodule

// ===== src/crrm_dp.sv =====
// ----------------------------------------------------------------------------
// crrm_dp: datapath of the range rights map
// Table and scratch memories, coverage walk, splitter, coalescer, copy-back.
// ----------------------------------------------------------------------------
module crrm_dp
    import crrm_pkg::*;
#(
    parameter int MAX_RANGES = 64,
    parameter int PERM_BITS  = 18
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  crrm_cmd_t                           cmd,
    input  logic                                in_mode,
    input  logic [63:0]                         in_start,
    input  logic [63:0]                         in_end,
    input  logic [PERM_BITS-1:0]                in_perms,
    input  logic                                in_sealed,
    input  logic                                in_via,
    output crrm_sts_t                           sts,
    output logic [$clog2(MAX_RANGES+1)-1:0]     count
);

    localparam int IW  = $clog2(MAX_RANGES);
    localparam int CW  = $clog2(MAX_RANGES + 1);
    localparam int SD  = 2 * MAX_RANGES + 4;
    localparam int SIW = $clog2(SD);
    localparam int SW  = $clog2(SD + 1);

    localparam logic [1:0] W_NONE  = 2'd0;
    localparam logic [1:0] W_RUN   = 2'd1;
    localparam logic [1:0] W_TRUE  = 2'd2;
    localparam logic [1:0] W_FALSE = 2'd3;

    typedef struct packed {
        logic [63:0]          lo;
        logic [63:0]          hi;
        logic [PERM_BITS-1:0] perms;
        logic                 sealed;
        logic                 via;
    } span_t;

    // item registers
    logic                 mode_reg;
    logic [63:0]          s_reg, e_reg;
    logic [PERM_BITS-1:0] p_reg;
    logic                 sl_reg, v_reg;

    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  idx_reg;
    logic [1:0]     wstat_reg;
    logic [63:0]    cur_reg;
    logic [3:0]     mask_reg;
    span_t          slot_reg [4];
    span_t          pend_reg;
    logic           pend_v_reg;
    logic [SW-1:0]  sn_reg;

    span_t tbl_mem [MAX_RANGES];
    span_t scr_mem [SD];
    span_t tbl_q, scr_q;

    // capture input fields
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg <= in_mode;
            s_reg    <= in_start;
            e_reg    <= in_end;
            p_reg    <= in_perms;
            sl_reg   <= in_sealed;
            v_reg    <= in_via;
        end
    end

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.tbl_rd)
            tbl_q <= tbl_mem[idx_reg[IW-1:0]];
        if (cmd.copy_wr)
            tbl_mem[idx_reg[IW-1:0]] <= scr_q;
    end

    // entry rights merged with new rights, and absorb test
    logic absorb;
    span_t newr;
    always_comb
    begin
        absorb = ((tbl_q.perms | p_reg) == tbl_q.perms) &&
                 (!tbl_q.sealed || sl_reg) && (!tbl_q.via || v_reg);
        newr        = '0;
        newr.perms  = p_reg;
        newr.sealed = sl_reg;
        newr.via    = v_reg;
    end

    // coverage walk step
    logic        wk_path;
    logic [63:0] wk_base;
    always_comb
    begin
        wk_path = (tbl_q.lo <= s_reg) || (wstat_reg == W_RUN);
        wk_base = (tbl_q.lo <= s_reg) ? s_reg : cur_reg;
    end

    // split geometry
    logic [63:0] cut_a, cut_b;
    always_comb
    begin
        cut_a = (tbl_q.lo > s_reg) ? tbl_q.lo : s_reg;
        cut_b = (tbl_q.hi < e_reg) ? tbl_q.hi : e_reg;
    end

    // lowest pending piece
    logic [1:0] sel;
    always_comb
    begin
        if (mask_reg[0])
            sel = 2'd0;
        else if (mask_reg[1])
            sel = 2'd1;
        else if (mask_reg[2])
            sel = 2'd2;
        else
            sel = 2'd3;
    end

    span_t push_x;
    logic  joinable;
    assign push_x   = slot_reg[sel];
    assign joinable = pend_v_reg && (pend_reg.hi == push_x.lo) &&
                      (pend_reg.perms == push_x.perms) &&
                      (pend_reg.sealed == push_x.sealed) &&
                      (pend_reg.via == push_x.via);

    // scratch memory: coalesced spans, registered read
    logic scr_we;
    assign scr_we = pend_v_reg && ((cmd.push && !joinable) || cmd.flush);
    always_ff @(posedge clk)
    begin
        if (scr_we)
            scr_mem[sn_reg[SIW-1:0]] <= pend_reg;
        if (cmd.copy_rd)
            scr_q <= scr_mem[SIW'(idx_reg[IW-1:0])];
    end

    // piece slots
    always_ff @(posedge clk)
    begin
        if (cmd.bld_arrive)
        begin
            if (tbl_q.lo >= e_reg)
                slot_reg[0] <= '{lo: cur_reg, hi: e_reg, perms: newr.perms,
                                 sealed: newr.sealed, via: newr.via};
            else
                slot_reg[0] <= '{lo: tbl_q.lo, hi: s_reg, perms: tbl_q.perms,
                                 sealed: tbl_q.sealed, via: tbl_q.via};
            slot_reg[1] <= '{lo: cur_reg, hi: cut_a, perms: p_reg,
                             sealed: sl_reg, via: v_reg};
            if (tbl_q.hi <= s_reg || tbl_q.lo >= e_reg)
                slot_reg[2] <= tbl_q;
            else
                slot_reg[2] <= '{lo: cut_a, hi: cut_b, perms: tbl_q.perms | p_reg,
                                 sealed: tbl_q.sealed & sl_reg,
                                 via: tbl_q.via & v_reg};
            slot_reg[3] <= '{lo: e_reg, hi: tbl_q.hi, perms: tbl_q.perms,
                             sealed: tbl_q.sealed, via: tbl_q.via};
        end
        else if (cmd.tail_arm)
        begin
            slot_reg[0] <= '{lo: cur_reg, hi: e_reg, perms: newr.perms,
                             sealed: newr.sealed, via: newr.via};
        end
        if (cmd.push && !joinable)
            pend_reg <= push_x;
        else if (cmd.push)
            pend_reg.hi <= push_x.hi;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            idx_reg    <= '0;
            wstat_reg  <= W_NONE;
            cur_reg    <= '0;
            mask_reg   <= '0;
            pend_v_reg <= 1'b0;
            sn_reg     <= '0;
        end
        else
        begin
            if (cmd.clr_count)
                count_reg <= '0;
            else if (cmd.commit)
                count_reg <= CW'(sn_reg);

            if (cmd.load_item || cmd.idx_clr || cmd.bld_init)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;

            if (cmd.load_item)
                wstat_reg <= W_NONE;
            else if (cmd.cov_eval && wk_path)
            begin
                if (tbl_q.lo > wk_base || tbl_q.hi <= wk_base || !absorb)
                    wstat_reg <= W_FALSE;
                else if (tbl_q.hi >= e_reg)
                    wstat_reg <= W_TRUE;
                else
                    wstat_reg <= W_RUN;
            end

            if (cmd.cov_eval && wk_path)
                cur_reg <= tbl_q.hi;
            else if (cmd.bld_init)
                cur_reg <= s_reg;
            else if (cmd.bld_arrive && tbl_q.hi > s_reg)
                cur_reg <= (tbl_q.lo < e_reg) ? cut_b : e_reg;
            else if (cmd.tail_arm)
                cur_reg <= e_reg;

            if (cmd.bld_init)
                mask_reg <= '0;
            else if (cmd.bld_arrive)
            begin
                if (tbl_q.hi <= s_reg)
                    mask_reg <= 4'b0100;
                else if (tbl_q.lo < e_reg)
                    mask_reg <= {tbl_q.hi > e_reg, 1'b1, cut_a > cur_reg,
                                 tbl_q.lo < s_reg};
                else
                    mask_reg <= {2'b01, 1'b0, cur_reg < e_reg};
            end
            else if (cmd.tail_arm)
                mask_reg <= {3'b000, cur_reg < e_reg};
            else if (cmd.push)
                mask_reg[sel] <= 1'b0;

            if (cmd.bld_init || cmd.flush)
                pend_v_reg <= 1'b0;
            else if (cmd.push)
                pend_v_reg <= 1'b1;

            if (cmd.bld_init)
                sn_reg <= '0;
            else if (scr_we)
                sn_reg <= sn_reg + 1'b1;
        end
    end

    // status
    always_comb
    begin
        sts.clear_mode  = mode_reg;
        sts.empty_range = (s_reg >= e_reg);
        sts.scan_end    = (idx_reg >= count_reg);
        sts.cov_true    = (wstat_reg == W_TRUE);
        sts.push_more   = |mask_reg;
        sts.ovf         = (sn_reg > SW'(MAX_RANGES));
        sts.copy_end    = (SW'(idx_reg) >= sn_reg);
    end

    assign count = count_reg;

endmodule

// ===== src/coalescing_range_rights_map_core.sv =====
// ----------------------------------------------------------------------------
// coalescing_range_rights_map_core: sorted range table with rights merging
// Top level: stream ports, output register, controller and datapath.
// ----------------------------------------------------------------------------
// One item is worked at a time. A clear or empty range goes straight to the
// result. An add runs a coverage scan over the stored entries, then, if not
// covered, a rebuild that splits each entry into pieces, and a copy back of
// the resulting entries into the table; the single table read port and the
// coalescer taking one piece a cycle set the pace. The table needs no
// clearing after reset. A result waits in an output register while the next
// item is accepted.
module coalescing_range_rights_map_core
    import crrm_pkg::*;
#(
    parameter int MAX_RANGES = 64,
    parameter int PERM_BITS  = 18
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // range_start, range_end, new_perms, new_sealed, new_via_trampoline
    input  logic [((130+PERM_BITS+7)/8)*8-1:0]   s_tdata,
    // mode
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // already_covered, table_overflow, entries_in_use[6:0]
    output logic [15:0]                          m_tdata
);

    localparam int CW = $clog2(MAX_RANGES + 1);

    crrm_cmd_t     cmd;
    crrm_sts_t     sts;
    logic          idle, res_load, res_cov, res_ovf, in_beat, out_free;
    logic [CW-1:0] count;
    logic          m_tvalid_reg;
    logic [15:0]   m_tdata_reg;

    assign s_tready = idle;
    assign in_beat  = s_tvalid && idle;
    assign out_free = !m_tvalid_reg || m_tready;

    crrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_beat  (in_beat),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .idle     (idle),
        .res_load (res_load),
        .res_cov  (res_cov),
        .res_ovf  (res_ovf)
    );

    crrm_dp #(
        .MAX_RANGES (MAX_RANGES),
        .PERM_BITS  (PERM_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_mode   (s_tuser),
        .in_start  (s_tdata[63:0]),
        .in_end    (s_tdata[127:64]),
        .in_perms  (s_tdata[128 +: PERM_BITS]),
        .in_sealed (s_tdata[128+PERM_BITS]),
        .in_via    (s_tdata[129+PERM_BITS]),
        .sts       (sts),
        .count     (count)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (res_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            m_tdata_reg <= {7'd0, 7'(count), res_ovf, res_cov};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // stored count never exceeds the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[8:2] <= 7'(MAX_RANGES)))
        else $error("entries_in_use above table depth");

    // covered and overflow are exclusive
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("covered and overflow both set");

    // an accepted beat makes the block busy
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready held after accept");

    // a result is loaded only into a free output register
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("pending result overwritten");
`endif

endmodule
